FILE: rtl/ipv6_text_address_parser_macros.svh
// assertion helpers shared by the parser modules
// each expects i_clk and i_rst_n in the scope where it is used
`ifndef IPV6_TEXT_ADDRESS_PARSER_MACROS_SVH
`define IPV6_TEXT_ADDRESS_PARSER_MACROS_SVH

// same-cycle implication, disabled in reset
`define IP6TP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ip6tp: same-cycle check failed");

// next-cycle implication, disabled in reset
`define IP6TP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ip6tp: next-cycle check failed");

`endif

FILE: rtl/ip6tp_pkg.sv
`default_nettype none

package ip6tp_pkg;

    // address shape
    localparam logic [3:0] NUM_GROUPS = 4'd8;
    localparam logic [2:0] MAX_DIGITS = 3'd4;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    // result status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_BAD    = 3'd1;
    localparam logic [2:0] ST_LONG   = 3'd2;
    localparam logic [2:0] ST_DCOLON = 3'd3;
    localparam logic [2:0] ST_MANY   = 3'd4;

    // final parse state of one address, handed to the expansion stage
    typedef struct packed {
        logic [2:0]       status;
        logic [3:0]       count;
        logic [3:0]       pos;
        logic             seen;
        logic [7:0][15:0] groups;
    } t_snap;

endpackage

`default_nettype wire

FILE: rtl/ip6tp_in_if.sv
`default_nettype none

interface ip6tp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       is_last;

    modport source (output valid, output text_char, output is_last, input ready);
    modport sink   (input valid, input text_char, input is_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/ip6tp_out_if.sv
`default_nettype none

interface ip6tp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] addr_high;
    logic [63:0] addr_low;

    modport source (output valid, output status, output addr_high, output addr_low,
                    input ready);
    modport sink   (input valid, input status, input addr_high, input addr_low,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/ipv6_text_address_parser.sv
// IPv6 text address parser. Characters of an address arrive one per request on
// i_in, with is_last set on the final one; for that character one result
// request leaves on o_out carrying a status (ok, bad character, group longer
// than four digits, second double colon, more than eight groups) and the
// 128-bit address split into addr_high (groups 0..3) and addr_low (groups
// 4..7), zero when the status is an error. The first error of an address
// sticks until its last character. The block takes one character every cycle,
// with the group state updated straight from an input register, except that a
// waiting result holds back a further last character, though not the
// characters in between. A result passes the input register, the state update
// into a snapshot and then the group expansion into the output register.
`default_nettype none

module ipv6_text_address_parser (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ip6tp_in_if.sink    i_in,
    ip6tp_out_if.source o_out
);

    logic             r_in_valid;
    logic [7:0]       r_in_char;
    logic             r_in_last;
    logic             fire;
    logic             out_free;
    logic             snap_valid;
    ip6tp_pkg::t_snap snap;

    // input register
    assign i_in.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_char <= i_in.text_char;
            r_in_last <= i_in.is_last;
        end
    end

    // group gathering
    ip6tp_state u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (r_in_valid),
        .i_text_char  (r_in_char),
        .i_is_last    (r_in_last),
        .i_out_free   (out_free),
        .o_fire       (fire),
        .o_snap_valid (snap_valid),
        .o_snap       (snap)
    );

    // compression expansion and result register
    ip6tp_expand u_expand (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .i_snap       (snap),
        .i_ready      (o_out.ready),
        .o_free       (out_free),
        .o_valid      (o_out.valid),
        .o_status     (o_out.status),
        .o_addr_high  (o_out.addr_high),
        .o_addr_low   (o_out.addr_low)
    );

endmodule

`default_nettype wire

FILE: rtl/ip6tp_state.sv
`default_nettype none

`include "ipv6_text_address_parser_macros.svh"

module ip6tp_state (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_item_valid,
    input  wire logic [7:0]     i_text_char,
    input  wire logic           i_is_last,
    input  wire logic           i_out_free,
    output logic                o_fire,
    output logic                o_snap_valid,
    output ip6tp_pkg::t_snap    o_snap
);

    logic [7:0][15:0] r_store, n_store;
    logic [3:0]       r_count, n_count;
    logic [15:0]      r_cur, n_cur;
    logic [2:0]       r_digit, n_digit;
    logic             r_prev, n_prev;
    logic             r_seen, n_seen;
    logic [3:0]       r_pos, n_pos;
    logic [2:0]       r_err, n_err;
    logic             r_snap_valid;
    ip6tp_pkg::t_snap r_snap;
    logic [4:0]       hex;
    logic             snap_free;

    // hex digit decode: {is_hex, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            return {1'b1, d[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    // a last character needs room in the snapshot stage
    assign snap_free = !r_snap_valid || i_out_free;
    assign o_fire    = i_item_valid && (!i_is_last || snap_free);
    assign hex       = hex_decode(i_text_char);

    // per-character state update
    always_comb begin
        n_store = r_store;
        n_count = r_count;
        n_cur   = r_cur;
        n_digit = r_digit;
        n_prev  = r_prev;
        n_seen  = r_seen;
        n_pos   = r_pos;
        n_err   = r_err;
        if (o_fire && r_err == ip6tp_pkg::ST_OK) begin
            if (hex[4]) begin
                if (r_digit >= ip6tp_pkg::MAX_DIGITS) begin
                    n_err = ip6tp_pkg::ST_LONG;
                end else begin
                    n_cur   = {r_cur[11:0], hex[3:0]};
                    n_digit = r_digit + 3'd1;
                    n_prev  = 1'b0;
                end
            end else begin
                // separator closes the open group
                if (r_digit != 3'd0) begin
                    if (r_count == ip6tp_pkg::NUM_GROUPS) begin
                        n_err = ip6tp_pkg::ST_MANY;
                    end else begin
                        for (int j = 0; j < 8; j++) begin
                            if (r_count[2:0] == 3'(j)) begin
                                n_store[j] = r_cur;
                            end
                        end
                        n_count = r_count + 4'd1;
                    end
                end
                n_cur   = 16'd0;
                n_digit = 3'd0;
                if (n_err == ip6tp_pkg::ST_OK) begin
                    if (i_text_char == ip6tp_pkg::CHAR_COLON) begin
                        if (r_prev) begin
                            if (r_seen) begin
                                n_err = ip6tp_pkg::ST_DCOLON;
                            end else begin
                                n_seen = 1'b1;
                                n_pos  = n_count;
                            end
                        end
                        if (n_err == ip6tp_pkg::ST_OK) begin
                            n_prev = 1'b1;
                        end
                    end else begin
                        n_err = ip6tp_pkg::ST_BAD;
                    end
                end
            end
            // end of text closes the open group
            if (i_is_last && n_err == ip6tp_pkg::ST_OK && n_digit != 3'd0) begin
                if (n_count == ip6tp_pkg::NUM_GROUPS) begin
                    n_err = ip6tp_pkg::ST_MANY;
                end else begin
                    for (int j = 0; j < 8; j++) begin
                        if (n_count[2:0] == 3'(j)) begin
                            n_store[j] = n_cur;
                        end
                    end
                    n_count = n_count + 4'd1;
                end
            end
        end
    end

    // parse state, cleared after each address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_fire && i_is_last)) begin
            r_store <= '0;
            r_count <= 4'd0;
            r_cur   <= 16'd0;
            r_digit <= 3'd0;
            r_prev  <= 1'b0;
            r_seen  <= 1'b0;
            r_pos   <= 4'd0;
            r_err   <= ip6tp_pkg::ST_OK;
        end else begin
            r_store <= n_store;
            r_count <= n_count;
            r_cur   <= n_cur;
            r_digit <= n_digit;
            r_prev  <= n_prev;
            r_seen  <= n_seen;
            r_pos   <= n_pos;
            r_err   <= n_err;
        end
    end

    // snapshot of the finished address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (o_fire && i_is_last) begin
            r_snap_valid <= 1'b1;
        end else if (i_out_free) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fire && i_is_last) begin
            r_snap.status <= n_err;
            r_snap.count  <= n_count;
            r_snap.pos    <= n_pos;
            r_snap.seen   <= n_seen;
            r_snap.groups <= n_store;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

    `IP6TP_ASSERT_IMP(a_count_range, 1'b1, r_count <= ip6tp_pkg::NUM_GROUPS)
    `IP6TP_ASSERT_IMP(a_digit_range, 1'b1, r_digit <= ip6tp_pkg::MAX_DIGITS)
    `IP6TP_ASSERT_IMP(a_pos_le_count, r_seen, r_pos <= r_count)
    `IP6TP_ASSERT_NXT(a_clear_after_last, o_fire && i_is_last, r_count == 4'd0 && r_digit == 3'd0 && r_err == ip6tp_pkg::ST_OK && !r_seen && r_snap_valid)
    `IP6TP_ASSERT_NXT(a_error_sticks, r_err != ip6tp_pkg::ST_OK && !(o_fire && i_is_last), r_err == $past(r_err))

endmodule

`default_nettype wire

FILE: rtl/ip6tp_expand.sv
`default_nettype none

module ip6tp_expand (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_snap_valid,
    input  wire ip6tp_pkg::t_snap i_snap,
    input  wire logic             i_ready,
    output logic                  o_free,
    output logic                  o_valid,
    output logic [2:0]            o_status,
    output logic [63:0]           o_addr_high,
    output logic [63:0]           o_addr_low
);

    logic [3:0]       head_len;
    logic [3:0]       shift_groups;
    logic [7:0][15:0] head;
    logic [7:0][15:0] tail;
    logic [127:0]     moved;
    logic [7:0][15:0] g;
    logic             r_valid;
    logic [2:0]       r_status;
    logic [63:0]      r_addr_high;
    logic [63:0]      r_addr_low;

    // groups before the double colon stay, the rest move to the end
    assign head_len     = i_snap.seen ? i_snap.pos : i_snap.count;
    assign shift_groups = ip6tp_pkg::NUM_GROUPS - i_snap.count;

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            head[j] = (4'(j) < head_len) ? i_snap.groups[j] : 16'd0;
            tail[j] = (4'(j) >= head_len && 4'(j) < i_snap.count) ?
                      i_snap.groups[j] : 16'd0;
        end
    end

    assign moved = 128'(tail) << {shift_groups, 4'd0};
    assign g     = (i_snap.status == ip6tp_pkg::ST_OK) ? (head | moved) : '0;

    // output register
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_snap_valid) begin
            r_status    <= i_snap.status;
            r_addr_high <= {g[0], g[1], g[2], g[3]};
            r_addr_low  <= {g[4], g[5], g[6], g[7]};
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_addr_high = r_addr_high;
    assign o_addr_low  = r_addr_low;

endmodule

`default_nettype wire

FILE: tb/ipv6_text_address_parser_tb.sv
`default_nettype none

module ipv6_text_address_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 100;

    // one parsed address as it should leave the block
    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } t_addr_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ip6tp_in_if  in_ch ();
    ip6tp_out_if out_ch ();

    ipv6_text_address_parser u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // parser state mirrored on the testbench side
    logic [15:0] grp_store [8];
    logic [3:0]  grp_cnt;
    logic [15:0] cur_grp;
    logic [2:0]  dig_cnt;
    logic        prev_colon;
    logic        dcolon_seen;
    logic [3:0]  dcolon_pos;
    logic [2:0]  parse_status;

    t_addr_result expected_addrs [$];
    logic [7:0]   addr_text [$];

    int  mismatches   = 0;
    int  chars_sent   = 0;
    int  quiet_cycles = 0;
    int  stall_left   = 0;
    logic src_gaps_on    = 1'b0;
    logic sink_stalls_on = 1'b0;

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap(input logic enable);
        int r;
        r = $urandom_range(0, 99);
        if (!enable || r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < MAX_REPORTS)
            $display("[%0t] mismatch on %s: got %h, want %h", $realtime, field, got, want);
        mismatches++;
    endtask

    task automatic clear_parse();
        for (int i = 0; i < 8; i++) grp_store[i] = '0;
        grp_cnt      = '0;
        cur_grp      = '0;
        dig_cnt      = '0;
        prev_colon   = 1'b0;
        dcolon_seen  = 1'b0;
        dcolon_pos   = '0;
        parse_status = ip6tp_pkg::ST_OK;
    endtask

    // close the open group, flagging a ninth one
    task automatic end_group();
        if (dig_cnt != 0) begin
            if (grp_cnt >= ip6tp_pkg::NUM_GROUPS) begin
                parse_status = ip6tp_pkg::ST_MANY;
            end else begin
                grp_store[grp_cnt] = cur_grp;
                grp_cnt++;
            end
        end
        cur_grp = '0;
        dig_cnt = '0;
    endtask

    // update the mirrored state with one character, queue a result on the last
    task automatic predict_char(input logic [7:0] c, input logic last);
        logic [3:0]   nib;
        logic         is_hex;
        logic [15:0]  g [8];
        int           cnt;
        int           pos;
        int           tail;
        t_addr_result res;

        if (parse_status == ip6tp_pkg::ST_OK) begin
            is_hex = 1'b1;
            nib    = '0;
            if (c >= "0" && c <= "9") nib = 4'(c - "0");
            else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 8'd10);
            else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 8'd10);
            else is_hex = 1'b0;

            if (is_hex) begin
                if (dig_cnt >= ip6tp_pkg::MAX_DIGITS) begin
                    parse_status = ip6tp_pkg::ST_LONG;
                end else begin
                    cur_grp    = {cur_grp[11:0], nib};
                    dig_cnt++;
                    prev_colon = 1'b0;
                end
            end else begin
                end_group();
                if (parse_status == ip6tp_pkg::ST_OK) begin
                    if (c != ip6tp_pkg::CHAR_COLON) begin
                        parse_status = ip6tp_pkg::ST_BAD;
                    end else if (prev_colon && dcolon_seen) begin
                        parse_status = ip6tp_pkg::ST_DCOLON;
                    end else begin
                        if (prev_colon) begin
                            dcolon_seen = 1'b1;
                            dcolon_pos  = grp_cnt;
                        end
                        prev_colon = 1'b1;
                    end
                end
            end
        end

        if (last) begin
            if (parse_status == ip6tp_pkg::ST_OK) end_group();
            for (int i = 0; i < 8; i++) g[i] = '0;
            if (parse_status == ip6tp_pkg::ST_OK) begin
                cnt  = int'(grp_cnt);
                pos  = int'(dcolon_pos);
                tail = cnt - pos;
                // groups after the double colon go to the end of the address
                for (int i = 0; i < 8; i++) begin
                    if (dcolon_seen && pos <= cnt) begin
                        if (i < pos) g[i] = grp_store[i];
                        else if (i >= 8 - tail) g[i] = grp_store[i + cnt - 8];
                    end else if (i < cnt) begin
                        g[i] = grp_store[i];
                    end
                end
            end
            res.status    = parse_status;
            res.addr_high = {g[0], g[1], g[2], g[3]};
            res.addr_low  = {g[4], g[5], g[6], g[7]};
            expected_addrs.push_back(res);
            clear_parse();
        end
    endtask

    // prediction on every accepted character
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            predict_char(in_ch.text_char, in_ch.is_last);
    end

    // result checking against the oldest expected address
    always @(posedge i_clk) begin : check_results
        t_addr_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_addrs.size() == 0) begin
                report_mismatch("unexpected result", out_ch.addr_high, '0);
            end else begin
                want = expected_addrs.pop_front();
                if (out_ch.status !== want.status)
                    report_mismatch("status", 64'(out_ch.status), 64'(want.status));
                if (out_ch.addr_high !== want.addr_high)
                    report_mismatch("addr_high", out_ch.addr_high, want.addr_high);
                if (out_ch.addr_low !== want.addr_low)
                    report_mismatch("addr_low", out_ch.addr_low, want.addr_low);
            end
        end
    end

    // watchdog on cycles with no request moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side backpressure
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            out_ch.ready <= 1'b1;
            stall_left   <= pick_gap(sink_stalls_on);
        end
    end

    // drive one character request and wait for it to be taken
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = pick_gap(src_gaps_on);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.text_char <= c;
        in_ch.is_last   <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        chars_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < addr_text.size(); i++)
            send_char(addr_text[i], i == addr_text.size() - 1);
    endtask

    task automatic send_string(input string s);
        addr_text.delete();
        for (int i = 0; i < s.len(); i++) addr_text.push_back(s[i]);
        send_text();
    endtask

    task automatic add_hex_group(input int ndig);
        int v;
        logic [7:0] ch;
        for (int i = 0; i < ndig; i++) begin
            v = $urandom_range(0, 15);
            if (v < 10) ch = 8'("0" + v);
            else ch = 8'(($urandom_range(0, 1) ? "A" : "a") + v - 10);
            addr_text.push_back(ch);
        end
    endtask

    // well-formed address with random groups and an optional double colon
    task automatic build_wellformed();
        int   n_grp;
        int   dc_at;
        logic use_dc;
        addr_text.delete();
        use_dc = ($urandom_range(0, 2) == 0);
        if (use_dc) n_grp = $urandom_range(0, 8);
        else n_grp = $urandom_range(0, 1) ? 8 : $urandom_range(1, 8);
        dc_at = $urandom_range(0, n_grp);
        for (int i = 0; i < n_grp; i++) begin
            if (use_dc && i == dc_at) begin
                addr_text.push_back(ip6tp_pkg::CHAR_COLON);
                addr_text.push_back(ip6tp_pkg::CHAR_COLON);
            end else if (i != 0) begin
                addr_text.push_back(ip6tp_pkg::CHAR_COLON);
            end
            add_hex_group($urandom_range(1, 4));
        end
        if (use_dc && dc_at == n_grp) begin
            addr_text.push_back(ip6tp_pkg::CHAR_COLON);
            addr_text.push_back(ip6tp_pkg::CHAR_COLON);
        end
    endtask

    // break a well-formed address in one of several ways
    task automatic corrupt_address();
        // characters just around the hex digit ranges, 8'h60 is the grave accent
        logic [7:0] near_hex [12] = '{"/", "0", "9", ":", ";", "@", "A", "F", "G", 8'h60,
                                      "a", "g"};
        int pos;
        int keep;
        pos = $urandom_range(0, addr_text.size());
        case ($urandom_range(0, 6))
            0: begin
                addr_text.insert(pos, 8'($urandom_range(0, 255)));
            end
            1: begin
                addr_text.push_back(ip6tp_pkg::CHAR_COLON);
                add_hex_group($urandom_range(5, 6));
            end
            2: begin
                addr_text.push_back(ip6tp_pkg::CHAR_COLON);
                addr_text.push_back(ip6tp_pkg::CHAR_COLON);
                add_hex_group($urandom_range(1, 4));
            end
            3: begin
                repeat ($urandom_range(1, 4)) begin
                    addr_text.push_back(ip6tp_pkg::CHAR_COLON);
                    add_hex_group($urandom_range(1, 4));
                end
            end
            4: begin
                repeat (3) addr_text.insert(pos, ip6tp_pkg::CHAR_COLON);
            end
            5: begin
                addr_text.insert(pos, near_hex[$urandom_range(0, 11)]);
            end
            default: begin
                keep = $urandom_range(1, addr_text.size() + 1);
                while (addr_text.size() > keep) void'(addr_text.pop_back());
            end
        endcase
        if (addr_text.size() == 0) addr_text.push_back(ip6tp_pkg::CHAR_COLON);
    endtask

    // edge cases of the grammar, one address each
    task automatic test_directed();
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        send_string("::");
        send_string("1::");
        send_string("::1");
        send_string("1:2:3:4:5:6:7:8");
        send_string("FFFF:ffff:0:00:000:0000:aBcD:9f9F");
        send_string("1:2:3:4:5:6:7:8:9");
        send_string("1:2:3:4:5:6:7:8:9:12345");
        send_string("1:2:3:4:5:6:7:8::");
        send_string("1:2:3:4::5:6:7:8");
        send_string("::1:2:3:4:5:6:7:8");
        send_string("1::2:3");
        send_string("12345");
        send_string("1:abcde:2");
        send_string(":::");
        send_string("1::2::3");
        send_string("1:g:2");
        send_string("1:/:2::3::");
        send_string(":1:");
        send_string("1");
        send_string("1:2:");
        send_string("1 :2");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
    endtask

    // well-formed addresses back to back, no idling anywhere
    task automatic test_wellformed_back_to_back();
        int stop_at;
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        stop_at = chars_sent + 350;
        while (chars_sent < stop_at) begin
            build_wellformed();
            send_text();
        end
    endtask

    // result side stalls while characters stream in
    task automatic test_result_backpressure();
        int stop_at;
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b1;
        stop_at = chars_sent + 300;
        while (chars_sent < stop_at) begin
            build_wellformed();
            if ($urandom_range(0, 4) == 0) corrupt_address();
            send_text();
        end
    endtask

    // mostly well-formed, a quarter broken, idling on both sides
    task automatic test_mixed_addresses();
        int stop_at;
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        stop_at = chars_sent + 600;
        while (chars_sent < stop_at) begin
            build_wellformed();
            if ($urandom_range(0, 3) == 0) corrupt_address();
            send_text();
        end
    endtask

    // arbitrary bytes with random address ends
    task automatic test_byte_noise();
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        repeat (150) send_char(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
        send_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.text_char = '0;
        in_ch.is_last   = 1'b0;
        out_ch.ready    = 1'b0;
        clear_parse();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_wellformed_back_to_back();
        test_result_backpressure();
        test_mixed_addresses();
        test_byte_noise();

        in_ch.valid <= 1'b0;
        while (expected_addrs.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
